[sv/arhd_pkg.sv]
// shared types and constants for the access range hazard detector
package arhd_pkg;

  localparam int OFFSET_BITS    = 16;
  localparam int THREAD_BITS    = 8;
  localparam int SLOT_BITS      = 3;
  localparam int DEF_SLOT_COUNT = 8;

  // function codes of a request
  localparam logic FUNC_ACCESS  = 1'b0;
  localparam logic FUNC_RELEASE = 1'b1;

  // status codes
  localparam logic STATUS_OK   = 1'b0;
  localparam logic STATUS_FAIL = 1'b1;

  typedef enum logic [1:0] {
    KIND_NONE = 2'd0,
    KIND_WAR  = 2'd1,
    KIND_RAW  = 2'd2,
    KIND_WAW  = 2'd3
  } kind_t;

  // incoming request
  typedef struct packed {
    logic                   func;
    logic                   is_write;
    logic [THREAD_BITS-1:0] thread;
    logic [OFFSET_BITS-1:0] start_offset;
    logic [OFFSET_BITS:0]   length;
  } in_t;

  // one result
  typedef struct packed {
    logic                   status;
    kind_t                  conflict_kind;
    logic [THREAD_BITS-1:0] other_thread;
    logic [SLOT_BITS-1:0]   slot_index;
    logic                   recorded;
    logic                   last;
  } out_t;

  // request token travelling down the cell chain
  typedef struct packed {
    logic                   func;
    logic                   is_write;
    logic                   fail;
    logic                   placed;
    logic [THREAD_BITS-1:0] thread;
    logic [OFFSET_BITS-1:0] lo;
    logic [OFFSET_BITS:0]   hi;
    logic [SLOT_BITS-1:0]   slot;
  } tok_t;

  // conflict report from one cell
  typedef struct packed {
    logic                   hit;
    kind_t                  kind;
    logic [THREAD_BITS-1:0] other;
    logic [SLOT_BITS-1:0]   slot;
  } rpt_t;

endpackage

[sv/arhd_cell.sv]
// one slot of the range table: compares the passing token, records or releases
module arhd_cell #(
  parameter int IDX = 0
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          tok_v_in,
  input  arhd_pkg::tok_t tok_in,
  output logic          tok_v_out,
  output arhd_pkg::tok_t tok_out,
  output arhd_pkg::rpt_t rpt
);
  import arhd_pkg::*;

  localparam logic [SLOT_BITS-1:0] SLOT_ID = SLOT_BITS'(IDX);

  logic                   tok_v_r;
  tok_t                   tok_r, tok_nxt;
  logic [THREAD_BITS-1:0] owner_r, owner_nxt;
  logic                   wr_r;
  logic [OFFSET_BITS-1:0] lo_r;
  logic [OFFSET_BITS:0]   hi_r;

  logic  own_match, occupied, overlap, active_acc, take;
  kind_t kind;

  // compare the token against this slot
  always_comb begin
    own_match  = (owner_r == tok_in.thread);
    occupied   = (owner_r != '0);
    overlap    = !(({1'b0, tok_in.lo} > hi_r) || (tok_in.hi < {1'b0, lo_r}));
    active_acc = tok_v_in && (tok_in.func == FUNC_ACCESS) && !tok_in.fail;
    if (wr_r) begin
      kind = tok_in.is_write ? KIND_WAW : KIND_RAW;
    end else begin
      kind = tok_in.is_write ? KIND_WAR : KIND_NONE;
    end
    rpt.hit   = active_acc && occupied && !own_match && overlap && (kind != KIND_NONE);
    rpt.kind  = kind;
    rpt.other = owner_r;
    rpt.slot  = SLOT_ID;
    take      = active_acc && !tok_in.placed && !occupied && (tok_in.thread != '0);
  end

  // next owner and outgoing token
  always_comb begin
    owner_nxt = owner_r;
    if (tok_v_in && (tok_in.func == FUNC_RELEASE) && own_match) begin
      owner_nxt = '0;
    end else if (take) begin
      owner_nxt = tok_in.thread;
    end
    tok_nxt = tok_in;
    if (take) begin
      tok_nxt.placed = 1'b1;
      tok_nxt.slot   = SLOT_ID;
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tok_v_r <= 1'b0;
      owner_r <= '0;
    end else begin
      tok_v_r <= tok_v_in;
      owner_r <= owner_nxt;
    end
  end

  // slot payload and token
  always_ff @(posedge clk) begin
    tok_r <= tok_nxt;
    if (take) begin
      wr_r <= tok_in.is_write;
      lo_r <= tok_in.lo;
      hi_r <= tok_in.hi;
    end
  end

  assign tok_v_out = tok_v_r;
  assign tok_out   = tok_r;

endmodule

[sv/access_range_hazard_detector.sv]
// top level of the access range hazard detector: request register, slot cell chain, result mux
// A request accepted while idle is registered, then walks the slot cells in order; each conflict
// and then the final result are registered to the output; at most one result per cycle, the
// receiver cannot stall. A new request is taken only after the token has walked the slot chain
// one cell per cycle; busy drops as the final result appears.
// Reset (synchronous, active low) empties every slot and clears busy and the result strobe.
module access_range_hazard_detector #(
  parameter int SLOT_COUNT = arhd_pkg::DEF_SLOT_COUNT
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           start,
  output logic           busy,
  input  arhd_pkg::in_t  in_data,
  output logic           out_valid,
  output arhd_pkg::out_t out_data
);
  import arhd_pkg::*;

  logic [SLOT_COUNT:0] tok_v;
  tok_t                tok [SLOT_COUNT+1];
  rpt_t                rpt [SLOT_COUNT];

  logic busy_r, busy_nxt;
  logic tok_v_r;
  tok_t tok_r;
  logic out_valid_r, out_valid_nxt;
  out_t out_data_r, out_data_nxt;
  logic accept;
  tok_t tok_new;
  rpt_t rpt_any;

  assign accept = start && !busy_r;

  // build the token for a new request
  always_comb begin
    tok_new          = '0;
    tok_new.func     = in_data.func;
    tok_new.is_write = in_data.is_write;
    tok_new.thread   = in_data.thread;
    tok_new.lo       = in_data.start_offset;
    tok_new.hi       = {1'b0, in_data.start_offset} + in_data.length - 1'b1;
    tok_new.fail     = (in_data.func == FUNC_ACCESS) && (in_data.length == '0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tok_v_r <= 1'b0;
      busy_r  <= 1'b0;
    end else begin
      tok_v_r <= accept;
      busy_r  <= busy_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      tok_r <= tok_new;
    end
  end

  assign tok_v[0] = tok_v_r;
  assign tok[0]   = tok_r;

  // chain of slot cells
  for (genvar i = 0; i < SLOT_COUNT; i++) begin : g_cell
    arhd_cell #(.IDX(i)) u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .tok_v_in (tok_v[i]),
      .tok_in   (tok[i]),
      .tok_v_out(tok_v[i+1]),
      .tok_out  (tok[i+1]),
      .rpt      (rpt[i])
    );
  end

  // collect the single active report
  always_comb begin
    rpt_any = '0;
    for (int k = 0; k < SLOT_COUNT; k++) begin
      rpt_any.hit   = rpt_any.hit | rpt[k].hit;
      rpt_any.kind  = kind_t'(rpt_any.kind | (rpt[k].kind & {2{rpt[k].hit}}));
      rpt_any.other = rpt_any.other | (rpt[k].other & {THREAD_BITS{rpt[k].hit}});
      rpt_any.slot  = rpt_any.slot | (rpt[k].slot & {SLOT_BITS{rpt[k].hit}});
    end
  end

  // result selection and busy
  always_comb begin
    busy_nxt      = busy_r;
    out_valid_nxt = 1'b0;
    out_data_nxt  = '0;
    if (accept) begin
      busy_nxt = 1'b1;
    end
    if (tok_v[SLOT_COUNT]) begin
      busy_nxt               = 1'b0;
      out_valid_nxt          = 1'b1;
      out_data_nxt.status    = tok[SLOT_COUNT].fail ? STATUS_FAIL : STATUS_OK;
      out_data_nxt.slot_index = tok[SLOT_COUNT].placed ? tok[SLOT_COUNT].slot : '0;
      out_data_nxt.recorded  = tok[SLOT_COUNT].placed;
      out_data_nxt.last      = 1'b1;
    end else if (rpt_any.hit) begin
      out_valid_nxt              = 1'b1;
      out_data_nxt.conflict_kind = rpt_any.kind;
      out_data_nxt.other_thread  = rpt_any.other;
      out_data_nxt.slot_index    = rpt_any.slot;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
  end

  assign busy      = busy_r;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

`ifndef NO_ASSERTIONS
  // only one request in the chain at a time
  a_one_token: assert property (@(posedge clk) disable iff (!rst_n)
    $countones(tok_v) <= 1)
    else $error("more than one request in the slot chain");

  // a request in flight keeps busy high
  a_busy_token: assert property (@(posedge clk) disable iff (!rst_n)
    (|tok_v) |-> busy_r)
    else $error("request in chain while not busy");

  // an accepted request enters the chain next cycle
  a_enter: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy_r) |=> tok_v_r)
    else $error("accepted request did not enter the chain");

  // the final result releases busy
  a_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_data_r.last) |-> !busy_r)
    else $error("final result while still busy");

  // conflict results are never final nor recorded
  a_conflict_form: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (out_data_r.conflict_kind != KIND_NONE))
      |-> (!out_data_r.last && !out_data_r.recorded))
    else $error("malformed conflict result");
`endif

endmodule

[tb/access_range_hazard_detector_test.sv]
`timescale 1ns / 1ps
// self-checking testbench for the access range hazard detector: queued requests, slot table mirror
module access_range_hazard_detector_test;
  import arhd_pkg::*;

  localparam int SLOTS        = DEF_SLOT_COUNT;
  localparam int QUIET_LIMIT  = 500;
  localparam int DRAIN_CYCLES = SLOTS + 6;
  localparam int CALM_TAIL    = 30;
  localparam int RANDOM_ITEMS = 145;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  in_t  in_data = '0;
  logic out_valid;
  out_t out_data;

  access_range_hazard_detector #(.SLOT_COUNT(SLOTS)) dut (
    .clk(clk),
    .rst_n(rst_n),
    .start(start),
    .busy(busy),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_data(out_data)
  );

  // 8 ns clock
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // mirror of the slot table
  logic [THREAD_BITS-1:0] owner_tab [SLOTS];
  logic                   writer_tab [SLOTS];
  logic [OFFSET_BITS-1:0] lo_tab [SLOTS];
  logic [OFFSET_BITS:0]   hi_tab [SLOTS];

  in_t  pending_requests [$];
  out_t expected_results [$];
  int   error_count = 0;
  logic request_taken = 1'b0;
  int   gap_left = 0;
  int   calm_left = 0;
  int   quiet_cycles = 0;

  function automatic out_t make_result(input logic status, input kind_t kind, input int other,
                                       input int slot, input logic rec, input logic last_flag);
    out_t r;
    r.status        = status;
    r.conflict_kind = kind;
    r.other_thread  = other[THREAD_BITS-1:0];
    r.slot_index    = slot[SLOT_BITS-1:0];
    r.recorded      = rec;
    r.last          = last_flag;
    return r;
  endfunction

  function automatic void queue_request(input logic func, input logic wr, input int thr,
                                        input int off, input int len);
    in_t r;
    r.func         = func;
    r.is_write     = wr;
    r.thread       = thr[THREAD_BITS-1:0];
    r.start_offset = off[OFFSET_BITS-1:0];
    r.length       = len[OFFSET_BITS:0];
    pending_requests.push_back(r);
  endfunction

  // work out the results of one request and update the mirrored table
  task automatic predict_hazards(input in_t req);
    logic [OFFSET_BITS:0] req_hi;
    int                   free_slot;
    kind_t                kind;
    free_slot = -1;
    if (req.func == FUNC_RELEASE) begin
      for (int i = 0; i < SLOTS; i++) begin
        if (owner_tab[i] == req.thread) begin
          owner_tab[i]  = '0;
          writer_tab[i] = 1'b0;
          lo_tab[i]     = '0;
          hi_tab[i]     = '0;
        end
      end
      expected_results.push_back(make_result(STATUS_OK, KIND_NONE, 0, 0, 1'b0, 1'b1));
      return;
    end
    if (req.length == '0) begin
      expected_results.push_back(make_result(STATUS_FAIL, KIND_NONE, 0, 0, 1'b0, 1'b1));
      return;
    end
    req_hi = {1'b0, req.start_offset} + req.length - 1'b1;
    // conflicts in slot order, skipping empty and own slots
    for (int i = 0; i < SLOTS; i++) begin
      if (owner_tab[i] != '0 && owner_tab[i] != req.thread &&
          !(req.start_offset > hi_tab[i] || req_hi < lo_tab[i])) begin
        kind = writer_tab[i] ? (req.is_write ? KIND_WAW : KIND_RAW)
                             : (req.is_write ? KIND_WAR : KIND_NONE);
        if (kind != KIND_NONE)
          expected_results.push_back(make_result(STATUS_OK, kind, owner_tab[i], i, 1'b0, 1'b0));
      end
    end
    // thread zero is never stored
    if (req.thread != '0) begin
      for (int i = 0; i < SLOTS; i++)
        if (free_slot < 0 && owner_tab[i] == '0) free_slot = i;
    end
    if (free_slot >= 0) begin
      owner_tab[free_slot]  = req.thread;
      writer_tab[free_slot] = req.is_write;
      lo_tab[free_slot]     = req.start_offset;
      hi_tab[free_slot]     = req_hi;
      expected_results.push_back(make_result(STATUS_OK, KIND_NONE, 0, free_slot, 1'b1, 1'b1));
    end else begin
      expected_results.push_back(make_result(STATUS_OK, KIND_NONE, 0, 0, 1'b0, 1'b1));
    end
  endtask

  task automatic report_mismatch(input string what);
    $display("%0t ns: mismatch: %s", $time, what);
    error_count++;
  endtask

  task automatic check_field(input string field, input logic [31:0] got,
                             input logic [31:0] want);
    if (got !== want)
      report_mismatch($sformatf("%s got %0h, want %0h", field, got, want));
  endtask

  // monitor: check results, then predict for a request taken at this edge
  always @(posedge clk) begin
    out_t want;
    if (!rst_n) begin
      for (int i = 0; i < SLOTS; i++) begin
        owner_tab[i]  = '0;
        writer_tab[i] = 1'b0;
        lo_tab[i]     = '0;
        hi_tab[i]     = '0;
      end
      request_taken <= 1'b0;
    end else begin
      if (out_valid) begin
        if (expected_results.size() == 0) begin
          report_mismatch($sformatf("unexpected result %h", out_data));
        end else begin
          want = expected_results.pop_front();
          check_field("status", out_data.status, want.status);
          check_field("conflict_kind", out_data.conflict_kind, want.conflict_kind);
          check_field("other_thread", out_data.other_thread, want.other_thread);
          check_field("slot_index", out_data.slot_index, want.slot_index);
          check_field("recorded", out_data.recorded, want.recorded);
          check_field("last", out_data.last, want.last);
        end
      end
      if (start && !busy) predict_hazards(in_data);
      request_taken <= start && !busy;
    end
  end

  // driver: hold a request until taken, with random idle bursts between requests
  always @(negedge clk) begin
    logic drive_next;
    drive_next = 1'b0;
    if (rst_n && !(start && !request_taken)) begin
      if (gap_left > 0) begin
        gap_left--;
      end else if (pending_requests.size() > 0) begin
        in_data <= pending_requests.pop_front();
        drive_next = 1'b1;
        if (calm_left > 0)
          calm_left--;
        else if (pending_requests.size() > CALM_TAIL && $urandom_range(0, 2) == 0)
          gap_left = $urandom_range(1, 13);
        else if ($urandom_range(0, 9) == 0)
          calm_left = $urandom_range(5, 20);
      end
      start <= drive_next;
    end
  end

  // watchdog on cycles with neither a request nor a result
  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // stimulus and end of run
  initial begin
    int pick;
    int thr;
    int off;
    int len;

    // directed: range extremes, all hazard kinds, adjacency, full table, thread zero
    queue_request(FUNC_ACCESS, 1'b0, 1, 0, 1);
    queue_request(FUNC_ACCESS, 1'b0, 2, 0, 65536);
    queue_request(FUNC_ACCESS, 1'b1, 3, 0, 1);
    queue_request(FUNC_ACCESS, 1'b0, 4, 65535, 1);
    queue_request(FUNC_ACCESS, 1'b1, 4, 65535, 65536);
    queue_request(FUNC_ACCESS, 1'b0, 1, 0, 10);
    queue_request(FUNC_ACCESS, 1'b1, 2, 5, 3);
    queue_request(FUNC_ACCESS, 1'b1, 255, 0, 65536);
    queue_request(FUNC_ACCESS, 1'b1, 170, 'hAAAA, 0);
    queue_request(FUNC_ACCESS, 1'b0, 0, 100, 1);
    queue_request(FUNC_ACCESS, 1'b1, 85, 'h5555, 'hAAAA);
    queue_request(FUNC_RELEASE, 1'b0, 0, 0, 0);
    queue_request(FUNC_RELEASE, 1'b1, 4, 'h1234, 'h10000);
    queue_request(FUNC_ACCESS, 1'b1, 9, 1, 1);
    queue_request(FUNC_ACCESS, 1'b0, 9, 65534, 2);
    queue_request(FUNC_RELEASE, 1'b0, 255, 0, 0);
    queue_request(FUNC_RELEASE, 1'b0, 1, 0, 0);
    queue_request(FUNC_RELEASE, 1'b0, 2, 0, 0);
    queue_request(FUNC_RELEASE, 1'b0, 3, 0, 0);
    queue_request(FUNC_RELEASE, 1'b0, 9, 0, 0);
    queue_request(FUNC_ACCESS, 1'b1, 7, 100, 10);
    queue_request(FUNC_ACCESS, 1'b1, 8, 110, 5);
    queue_request(FUNC_ACCESS, 1'b0, 8, 90, 10);
    queue_request(FUNC_RELEASE, 1'b0, 7, 0, 0);
    queue_request(FUNC_RELEASE, 1'b0, 8, 0, 0);

    // random: few threads and clustered offsets so ranges collide often
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      pick = $urandom_range(0, 99);
      thr = (pick < 80) ? $urandom_range(1, 5) : (pick < 85) ? 0 : $urandom_range(1, 255);
      if ($urandom_range(0, 99) < 18) begin
        queue_request(FUNC_RELEASE, $urandom_range(0, 1), thr, $urandom_range(0, 65535),
                      $urandom_range(0, 65536));
      end else begin
        pick = $urandom_range(0, 99);
        off = (pick < 70) ? $urandom_range(0, 255)
            : (pick < 85) ? $urandom_range(65280, 65535) : $urandom_range(0, 65535);
        pick = $urandom_range(0, 99);
        len = (pick < 5) ? 0 : (pick < 10) ? 65536
            : (pick < 80) ? $urandom_range(1, 64) : $urandom_range(1, 65536);
        queue_request(FUNC_ACCESS, $urandom_range(0, 1), thr, off, len);
      end
    end

    repeat (11) @(posedge clk);
    @(negedge clk) rst_n <= 1'b1;

    while (pending_requests.size() > 0 || start || expected_results.size() > 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (error_count == 0)
      $display("ALL CHECKS PASSED");
    else
      $display("CHECKS FAILED");
    $finish;
  end

endmodule

[files.f]
sv/arhd_pkg.sv
sv/arhd_cell.sv
sv/access_range_hazard_detector.sv
tb/access_range_hazard_detector_test.sv
